/* rtl/tcw_pkg.sv */
// Package for the text console writer: field widths, character codes, command and op types.
`timescale 1ns / 1ps
`default_nettype none
package tcw_pkg;

  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 11;
  localparam int POS_W  = 11;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;

  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_LAST  = 8'h7F;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;
  localparam int                TAB_STOP   = 8;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_BS    = 3'd1,
    OP_TAB   = 3'd2,
    OP_CR    = 3'd3,
    OP_LF    = 3'd4,
    OP_PRINT = 3'd5,
    OP_CLEAR = 3'd6,
    OP_READ  = 3'd7
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [CHAR_W-1:0]  ch;
    logic [IDX_W-1:0]   idx;
    logic               idx_ok;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } fwd_t;

  typedef struct packed {
    logic pop;
    logic init;
  } bwd_t;

  typedef enum logic [4:0] {
    ST_INIT   = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_READ   = 5'b00100,
    ST_SCROLL = 5'b01000,
    ST_BLANK  = 5'b10000
  } state_e;

endpackage
`default_nettype wire

/* rtl/tcw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

/* rtl/tcw_front.sv */
// Front end: accepts commands, classifies them and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none
module tcw_front #(
  parameter int NCELLS = 2000
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [tcw_pkg::CMD_W-1:0]  command_i,
  input  wire logic [tcw_pkg::CHAR_W-1:0] char_code_i,
  input  wire logic [tcw_pkg::IDX_W-1:0]  read_index_i,
  output tcw_pkg::fwd_t                   fwd_o,
  input  wire tcw_pkg::bwd_t              bwd_i
);
  import tcw_pkg::*;

  localparam int DEPTH = 2;

  cmd_t       cls;
  cmd_t       entry_q [DEPTH];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       acc;

  always_comb begin
    cls.ch     = char_code_i;
    cls.idx    = read_index_i;
    cls.idx_ok = 32'(read_index_i) < NCELLS;
    cls.op     = OP_NONE;
    case (command_i)
      CMD_PUT: begin
        case (char_code_i)
          CHAR_BS:  cls.op = OP_BS;
          CHAR_TAB: cls.op = OP_TAB;
          CHAR_CR:  cls.op = OP_CR;
          CHAR_LF:  cls.op = OP_LF;
          default: begin
            if (char_code_i inside {[CHAR_SPACE:CHAR_LAST]}) begin
              cls.op = OP_PRINT;
            end
          end
        endcase
      end
      CMD_CLEAR: cls.op = OP_CLEAR;
      CMD_READ:  cls.op = OP_READ;
      default:   cls.op = OP_NONE;
    endcase
  end

  assign full = (cnt_q == 2'(DEPTH)) || bwd_i.init;
  assign acc  = push && !full;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (acc) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (bwd_i.pop) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (acc && !bwd_i.pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!acc && bwd_i.pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      entry_q[wr_ptr_q] <= cls;
    end
  end

  assign fwd_o.valid = (cnt_q != 2'd0);
  assign fwd_o.cmd   = entry_q[rd_ptr_q];

endmodule
`default_nettype wire

/* rtl/tcw_back.sv */
// Back end: cursor, cell buffer sequencing for scroll, clear and read, and the result register.
`timescale 1ns / 1ps
`default_nettype none
module tcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire tcw_pkg::fwd_t              fwd_i,
  output tcw_pkg::bwd_t                   bwd_o,
  input  wire logic [tcw_pkg::ATTR_W-1:0] attr_i,
  output logic                            empty,
  input  wire logic                       pop,
  output logic      [tcw_pkg::POS_W-1:0]  cursor_pos_o,
  output logic      [tcw_pkg::CELL_W-1:0] cell_data_o,
  output logic                            scrolled_o
);
  import tcw_pkg::*;

  localparam int NCELLS = ROWS * COLUMNS;
  localparam int AW     = $clog2(NCELLS);
  localparam int CW     = $clog2(NCELLS + 1);
  localparam int PW     = $clog2(NCELLS);
  localparam int COLW   = $clog2(COLUMNS);
  localparam int ROWW   = $clog2(ROWS);
  localparam int LAST_ROW_START = (ROWS - 1) * COLUMNS;

  state_e            state_q, state_d;
  logic [COLW-1:0]   col_q, col_d;
  logic [ROWW-1:0]   row_q, row_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              scr_q, scr_d;
  logic              rd_ok_q, rd_ok_d;

  logic              out_vld_q, out_vld_d;
  logic [POS_W-1:0]  pos_q;
  logic [CELL_W-1:0] cell_q, cell_d;
  logic              oscr_q, oscr_d;
  logic              res_set;

  logic              take;
  logic [COLW:0]     col_w;
  logic [ROWW:0]     row_w;
  logic [PW-1:0]     pos_n;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [CELL_W-1:0] wdata, rdata;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (NCELLS),
    .AW    (AW)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign take = (state_q == ST_IDLE) && fwd_i.valid && !out_vld_q;
  assign bwd_o.pop  = take;
  assign bwd_o.init = (state_q == ST_INIT);

  always_comb begin
    col_w = {1'b0, col_q};
    row_w = {1'b0, row_q};
    case (fwd_i.cmd.op)
      OP_BS: begin
        if (col_q != '0) begin
          col_w = {1'b0, col_q} - (COLW+1)'(1);
        end
      end
      OP_TAB:   col_w = ({1'b0, col_q} + (COLW+1)'(TAB_STOP)) & ~((COLW+1)'(TAB_STOP - 1));
      OP_CR:    col_w = '0;
      OP_LF: begin
        col_w = '0;
        row_w = {1'b0, row_q} + (ROWW+1)'(1);
      end
      OP_PRINT: col_w = {1'b0, col_q} + (COLW+1)'(1);
      default:  col_w = {1'b0, col_q};
    endcase
    if (col_w >= (COLW+1)'(COLUMNS)) begin
      col_w = '0;
      row_w = row_w + (ROWW+1)'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    row_d   = row_q;
    cnt_d   = cnt_q;
    scr_d   = scr_q;
    rd_ok_d = rd_ok_q;
    res_set = 1'b0;
    cell_d  = '0;
    oscr_d  = 1'b0;
    we      = 1'b0;
    waddr   = AW'(cnt_q);
    wdata   = {attr_i, CHAR_SPACE};
    raddr   = AW'(cnt_q);
    case (state_q)
      ST_INIT: begin
        we    = 1'b1;
        wdata = '0;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(NCELLS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        raddr = AW'(fwd_i.cmd.idx);
        if (take) begin
          case (fwd_i.cmd.op)
            OP_READ: begin
              rd_ok_d = fwd_i.cmd.idx_ok;
              state_d = ST_READ;
            end
            OP_CLEAR: begin
              col_d   = '0;
              row_d   = '0;
              cnt_d   = '0;
              scr_d   = 1'b0;
              state_d = ST_BLANK;
            end
            default: begin
              if (fwd_i.cmd.op == OP_PRINT) begin
                we    = 1'b1;
                waddr = AW'(PW'(row_q) * PW'(COLUMNS) + PW'(col_q));
                wdata = {attr_i, fwd_i.cmd.ch};
              end
              col_d = col_w[COLW-1:0];
              if (row_w == (ROWW+1)'(ROWS)) begin
                row_d   = ROWW'(ROWS - 1);
                cnt_d   = CW'(COLUMNS);
                scr_d   = 1'b1;
                state_d = ST_SCROLL;
              end else begin
                row_d   = row_w[ROWW-1:0];
                res_set = 1'b1;
              end
            end
          endcase
        end
      end
      ST_READ: begin
        res_set = 1'b1;
        cell_d  = rd_ok_q ? rdata : '0;
        state_d = ST_IDLE;
      end
      ST_SCROLL: begin
        if (cnt_q > CW'(COLUMNS)) begin
          we    = 1'b1;
          waddr = AW'(cnt_q - CW'(COLUMNS + 1));
          wdata = rdata;
        end
        if (cnt_q == CW'(NCELLS)) begin
          cnt_d   = CW'(LAST_ROW_START);
          state_d = ST_BLANK;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      ST_BLANK: begin
        we    = 1'b1;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(NCELLS - 1)) begin
          res_set = 1'b1;
          oscr_d  = scr_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign pos_n = PW'(row_d) * PW'(COLUMNS) + PW'(col_d);

  always_comb begin
    out_vld_d = out_vld_q;
    if (pop && out_vld_q) begin
      out_vld_d = 1'b0;
    end
    if (res_set) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      col_q     <= '0;
      row_q     <= '0;
      cnt_q     <= '0;
      scr_q     <= 1'b0;
      rd_ok_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      col_q     <= col_d;
      row_q     <= row_d;
      cnt_q     <= cnt_d;
      scr_q     <= scr_d;
      rd_ok_q   <= rd_ok_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_set) begin
      pos_q  <= POS_W'(pos_n);
      cell_q <= cell_d;
      oscr_q <= oscr_d;
    end
  end

  assign empty        = !out_vld_q;
  assign cursor_pos_o = pos_q;
  assign cell_data_o  = cell_q;
  assign scrolled_o   = oscr_q;

endmodule
`default_nettype wire

/* rtl/text_console_char_writer_top.sv */
// Top level of the text console writer: attribute register, front end and back end.
//
//   channel   handshake      payload
//   -------   ------------   -------------------------------------------
//   command   push / full    command_i, char_code_i, read_index_i
//   result    empty / pop    cursor_pos_o, cell_data_o, scrolled_o
//   config    text_attr_we_i text_attr_i (text attribute, reset 0x0F)
//
// Cursor moves and prints that do not scroll complete in the back end's idle state
// as the command is taken; a read also passes through the read state. A scroll
// copies each row but the first up one row through the cell RAM and then blanks
// the last row; a clear blanks every cell. After reset the RAM is zeroed while
// full stays high. A two-entry command queue and the result register let the
// producer and consumer stall independently.
`timescale 1ns / 1ps
`default_nettype none
module text_console_char_writer_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [tcw_pkg::CMD_W-1:0]  command_i,
  input  wire logic [tcw_pkg::CHAR_W-1:0] char_code_i,
  input  wire logic [tcw_pkg::IDX_W-1:0]  read_index_i,
  output logic                            empty,
  input  wire logic                       pop,
  output logic      [tcw_pkg::POS_W-1:0]  cursor_pos_o,
  output logic      [tcw_pkg::CELL_W-1:0] cell_data_o,
  output logic                            scrolled_o,
  input  wire logic                       text_attr_we_i,
  input  wire logic [tcw_pkg::ATTR_W-1:0] text_attr_i
);
  import tcw_pkg::*;

  logic [ATTR_W-1:0] attr_q;
  fwd_t              fwd;
  bwd_t              bwd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (text_attr_we_i) begin
      attr_q <= text_attr_i;
    end
  end

  tcw_front #(
    .NCELLS (ROWS * COLUMNS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .command_i    (command_i),
    .char_code_i  (char_code_i),
    .read_index_i (read_index_i),
    .fwd_o        (fwd),
    .bwd_i        (bwd)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fwd_i        (fwd),
    .bwd_o        (bwd),
    .attr_i       (attr_q),
    .empty        (empty),
    .pop          (pop),
    .cursor_pos_o (cursor_pos_o),
    .cell_data_o  (cell_data_o),
    .scrolled_o   (scrolled_o)
  );

endmodule
`default_nettype wire
